// ===== rtl/core/bbc_pkg.sv =====
// bbc_pkg: shared types, codes and helpers for the bracket balance checker
// used by bbc_core and bracket_balance_checker
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int LIMIT_W     = 9;
  localparam int CNT_W       = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd100;

  localparam logic [7:0] CH_RND_OPEN = 8'h28;
  localparam logic [7:0] CH_RND_CLOSE = 8'h29;
  localparam logic [7:0] CH_SQR_OPEN = 8'h5b;
  localparam logic [7:0] CH_SQR_CLOSE = 8'h5d;
  localparam logic [7:0] CH_CRL_OPEN = 8'h7b;
  localparam logic [7:0] CH_CRL_CLOSE = 8'h7d;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_BALANCED  = 3'd1,
    V_MISMATCH  = 3'd2,
    V_UNDERFLOW = 3'd3,
    V_UNCLOSED  = 3'd4,
    V_OVERFLOW  = 3'd5
  } verdict_t;

  typedef struct packed {
    verdict_t         verdict;
    logic             done_res;
    logic [CNT_W-1:0] depth;
  } result_t;

  function automatic kind_t opener_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_RND_OPEN: k = KIND_ROUND;
      CH_SQR_OPEN: k = KIND_SQUARE;
      CH_CRL_OPEN: k = KIND_CURLY;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_RND_CLOSE: k = KIND_ROUND;
      CH_SQR_CLOSE: k = KIND_SQUARE;
      CH_CRL_CLOSE: k = KIND_CURLY;
      default:      k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/bracket_balance_checker.sv =====
// bracket_balance_checker: top level with limit register and output register
// depends on bbc_pkg and bbc_core
//
// usage:
//   in_tdata carries one character per request, in_tlast marks the last
//   character of an expression. every accepted character gives exactly one
//   result on the out_ channel: verdict and depth in out_tdata, out_tlast set
//   when the verdict is final for the expression.
//   cfg_valid/cfg_data writes the stack limit (largest number of open
//   brackets); cfg_ready is always high. write it only while the block idles.
//   output: a result is registered and valid in the cycle after its character is accepted.
//   throughput: one character per cycle while out_tready is high; the stack top and the entry below it
//   sit in registers, and the stack ram is read one pop ahead.
//   reset: stack empty, no error, limit 100; the ram needs no clearing.
//   stall: one output register; in_tready follows out_tready while a result
//   is held, so the input stalls exactly when the result cannot move.
`timescale 1ns / 1ps

module bracket_balance_checker #(
  parameter int DEPTH = bbc_pkg::STACK_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // sym[7:0]
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // verdict[2:0], depth[11:3], zero[15:12]
  output logic                        out_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bbc_pkg::LIMIT_W-1:0] cfg_data
);
  import bbc_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  result_t            res, res_r;
  logic               fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  bbc_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .sym         (in_tdata),
    .last        (in_tlast),
    .stack_limit (limit_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.done_res;
  assign out_tdata  = {4'b0, res_r.depth, res_r.verdict};

endmodule

// ===== rtl/core/bbc_ram.sv =====
// bbc_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bbc_core.sv =====
// bbc_core: bracket stack control, top and next-below entries held in registers
// depends on bbc_pkg and bbc_ram
`timescale 1ns / 1ps

module bbc_core #(
  parameter int DEPTH = bbc_pkg::STACK_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [7:0]                   sym,
  input  logic                         last,
  input  logic [bbc_pkg::LIMIT_W-1:0]  stack_limit,
  output bbc_pkg::result_t             res
);
  import bbc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = (AW > CNT_W) ? AW : CNT_W;

  logic [CNT_W-1:0] depth_r, depth_nxt, depth_after;
  verdict_t         err_r, err_nxt, err_after;
  kind_t            top_r, top_nxt;
  kind_t            below_r, below_nxt, below_cur;
  logic             sel_mem_r, sel_mem_nxt;
  kind_t            rd_data;

  kind_t   open_k, close_k;
  logic    ok, room, is_push, is_pop, ovf, unf, mism;
  logic [IW-1:0] depth_ext, rd_ext;
  logic [AW-1:0] waddr, raddr;

  assign open_k  = opener_kind(sym);
  assign close_k = closer_kind(sym);
  assign ok      = (err_r == V_OK);
  assign room    = (32'(depth_r) < 32'(stack_limit)) && (32'(depth_r) < DEPTH);

  assign is_push = ok && (open_k != KIND_NONE) && room;
  assign ovf     = ok && (open_k != KIND_NONE) && !room;
  assign is_pop  = ok && (open_k == KIND_NONE) && (close_k != KIND_NONE) && (depth_r != '0);
  assign unf     = ok && (open_k == KIND_NONE) && (close_k != KIND_NONE) && (depth_r == '0);
  assign mism    = is_pop && (top_r != close_k);

  assign below_cur = sel_mem_r ? rd_data : below_r;

  assign depth_ext = IW'(depth_r);
  assign rd_ext    = depth_ext - IW'(3);
  assign waddr     = depth_ext[AW-1:0];
  assign raddr     = rd_ext[AW-1:0];

  always_comb begin
    depth_after = depth_r;
    if (is_push) begin
      depth_after = depth_r + CNT_W'(1);
    end else if (is_pop) begin
      depth_after = depth_r - CNT_W'(1);
    end

    if (ovf) begin
      err_after = V_OVERFLOW;
    end else if (unf) begin
      err_after = V_UNDERFLOW;
    end else if (mism) begin
      err_after = V_MISMATCH;
    end else begin
      err_after = err_r;
    end

    res.depth    = depth_after;
    res.done_res = last;
    if (!last) begin
      res.verdict = err_after;
    end else if (err_after != V_OK) begin
      res.verdict = err_after;
    end else if (depth_after != '0) begin
      res.verdict = V_UNCLOSED;
    end else begin
      res.verdict = V_BALANCED;
    end
  end

  always_comb begin
    depth_nxt   = depth_r;
    err_nxt     = err_r;
    top_nxt     = top_r;
    below_nxt   = below_r;
    sel_mem_nxt = sel_mem_r;
    if (fire) begin
      depth_nxt   = last ? '0 : depth_after;
      err_nxt     = last ? V_OK : err_after;
      below_nxt   = below_cur;
      sel_mem_nxt = 1'b0;
      if (is_push) begin
        // old top becomes the entry below the new one
        top_nxt   = open_k;
        below_nxt = top_r;
      end else if (is_pop) begin
        // entry below the new top arrives from the ram next cycle
        top_nxt     = below_cur;
        sel_mem_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      err_r     <= V_OK;
      sel_mem_r <= 1'b0;
    end else begin
      depth_r   <= depth_nxt;
      err_r     <= err_nxt;
      sel_mem_r <= sel_mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    below_r <= below_nxt;
  end

  bbc_ram #(
    .WIDTH ($bits(kind_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (fire && is_push),
    .waddr (waddr),
    .wdata (open_k),
    .re    (fire && is_pop),
    .raddr (raddr),
    .rdata (rd_data)
  );

endmodule
